>>> sv/assert_macros.svh
// Assertion macros for the RTL; sset_dp includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define SVA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Implication: the consequent is checked wherever the antecedent holds.
`define SVA_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
        else $error(msg);

`endif

>>> sv/sset_pkg.sv
// Shared types and constants for the sorted set insertion block.
package sset_pkg;

    localparam int VALUE_W  = 12;
    localparam int COUNT_W  = 9;
    localparam int SUM_W    = 20;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_COMPARE,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_INSERT,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    ptr_inc;
        logic    sh_init;
        logic    sh_rd;
        logic    sh_wr;
        logic    insert;
        logic    set_status;
        status_t status;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic value_zero;
        logic ptr_at_end;
        logic rd_lt;
        logic rd_eq;
        logic full;
        logic sh_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> sv/sset_ctrl.sv
// Sequencer for search, shift and insert of one value.
module sset_ctrl
    import sset_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.value_zero)      state_next = S_DONE;
                else if (stat.ptr_at_end) state_next = stat.full ? S_DONE : S_SHIFT_CHK;
                else                      state_next = S_COMPARE;
            end
            S_COMPARE: begin
                if (stat.rd_eq)      state_next = S_DONE;
                else if (stat.rd_lt) state_next = S_CHECK;
                else                 state_next = stat.full ? S_DONE : S_SHIFT_CHK;
            end
            S_SHIFT_CHK: begin
                state_next = stat.sh_done ? S_INSERT : S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                state_next = S_SHIFT_CHK;
            end
            S_INSERT: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_CHECK: begin
                if (stat.value_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_RANGE;
                end else if (stat.ptr_at_end) begin
                    if (stat.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                    end else begin
                        cmd.sh_init = 1'b1;
                    end
                end
            end
            S_COMPARE: begin
                if (stat.rd_eq) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DUPLICATE;
                end else if (stat.rd_lt) begin
                    cmd.ptr_inc = 1'b1;
                end else if (stat.full) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                end else begin
                    cmd.sh_init = 1'b1;
                end
            end
            S_SHIFT_CHK: begin
                cmd.sh_rd = !stat.sh_done;
            end
            S_SHIFT_WR: begin
                cmd.sh_wr = 1'b1;
            end
            S_INSERT: begin
                cmd.insert     = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_INSERTED;
            end
            S_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/sset_dp.sv
// Member store, search and shift pointers, running totals and result register.
`include "assert_macros.svh"

module sset_dp
    import sset_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                s_restart,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_count,
    output logic [VALUE_W-1:0]  m_smallest,
    output logic [VALUE_W-1:0]  m_largest,
    output logic [SUM_W-1:0]    m_total
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [VALUE_W-1:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [VALUE_W-1:0] min_reg, max_reg;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      sh_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    status_t            status_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [VALUE_W-1:0]  m_smallest_reg, m_largest_reg;
    logic [SUM_W-1:0]    m_total_reg;

    logic [CW-1:0]      sh_minus;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    assign sh_minus = sh_reg - CW'(1);
    assign rd_addr  = cmd.sh_rd ? sh_minus[AW-1:0] : ptr_reg[AW-1:0];

    // one write port: shift moves an entry up, insert drops the new value in
    always_comb begin
        wr_en   = cmd.sh_wr | cmd.insert;
        wr_addr = cmd.sh_wr ? sh_reg[AW-1:0] : ptr_reg[AW-1:0];
        wr_data = cmd.sh_wr ? rd_data_reg : value_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        stat.value_zero = (value_reg == '0);
        stat.ptr_at_end = (ptr_reg == count_reg);
        stat.rd_lt      = (rd_data_reg < value_reg);
        stat.rd_eq      = (rd_data_reg == value_reg);
        stat.full       = (count_reg >= CW'(CAPACITY));
        stat.sh_done    = (sh_reg == ptr_reg);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ptr_reg   <= '0;
            sh_reg    <= '0;
        end else begin
            if (cmd.load) begin
                ptr_reg <= '0;
                if (s_restart) begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
            end
            if (cmd.ptr_inc) ptr_reg <= ptr_reg + CW'(1);
            if (cmd.sh_init) sh_reg <= count_reg;
            if (cmd.sh_wr)   sh_reg <= sh_minus;
            if (cmd.insert) begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + SUM_W'(value_reg);
            end
        end
    end

    // payload: value, extremes, status
    always_ff @(posedge aclk) begin
        if (cmd.load) value_reg <= s_value;
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.insert) begin
            if (count_reg == '0) begin
                min_reg <= value_reg;
                max_reg <= value_reg;
            end else begin
                if (ptr_reg == '0)       min_reg <= value_reg;
                if (ptr_reg == count_reg) max_reg <= value_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg   <= status_reg;
            m_count_reg    <= COUNT_W'(count_reg);
            m_smallest_reg <= (count_reg == '0) ? '0 : min_reg;
            m_largest_reg  <= (count_reg == '0) ? '0 : max_reg;
            m_total_reg    <= sum_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_count    = m_count_reg;
    assign m_smallest = m_smallest_reg;
    assign m_largest  = m_largest_reg;
    assign m_total    = m_total_reg;

    `SVA_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CW'(CAPACITY), "count above capacity")
    `SVA_IMPLY(a_ins_grow, aclk, aresetn, cmd.insert, ##1 (count_reg == $past(count_reg) + CW'(1)), "insert did not grow count")
    `SVA_IMPLY(a_out_free, aclk, aresetn, cmd.out_load, stat.out_free, "result overwrote a pending transfer")
    `SVA_IMPLY(a_min_max, aclk, aresetn, count_reg != '0, (min_reg <= max_reg), "smallest above largest")

endmodule

>>> sv/sorted_set_insert.sv
// Top level of the sorted set insertion block: controller plus datapath.
//
// Channel  Dir  Ports                     Contents
// s_       in   tvalid tready tdata tuser tdata[11:0] value; tuser[0] restart
// m_       out  tvalid tready tdata tuser tdata count/smallest/largest/total;
//                                         tuser[1:0] status
//
// Sequence: IDLE takes the transfer; the search passes each member through CHECK
// and COMPARE, the shift moves each member through SHIFT_CHK and SHIFT_WR, then
// INSERT writes the value, DONE loads the result; rejects skip shift and insert.
// The member RAM has a registered read port, so a read and the use of its data fall in separate states.
// Reset clears count and sum at once; the member RAM needs no clearing pass.
// A stalled m_ side holds the result in DONE; no new item is taken until it leaves.
module sorted_set_insert
    import sset_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] value, [15:12] zero
    input  logic [0:0]          s_tuser,   // [0] restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [8:0] count, [20:9] smallest,
                                           // [32:21] largest, [52:33] total,
                                           // [55:53] zero
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [COUNT_W-1:0] m_count;
    logic [VALUE_W-1:0] m_smallest, m_largest;
    logic [SUM_W-1:0]   m_total;

    sset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sset_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_restart  (s_tuser[0]),
        .s_value    (s_tdata[VALUE_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_tuser),
        .m_count    (m_count),
        .m_smallest (m_smallest),
        .m_largest  (m_largest),
        .m_total    (m_total)
    );

    // pack result fields, lowest field first, zero fill to whole bytes
    assign m_tdata = {3'b000, m_total, m_largest, m_smallest, m_count};

endmodule

>>> test/sorted_set_insert_tb.sv
// Testbench for sorted_set_insert: directed and random transfers checked against a set predictor.
module sorted_set_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sset_pkg::*;

    localparam int SET_CAPACITY   = 256;
    localparam int VALUE_MAX      = (1 << VALUE_W) - 1;
    // ITEM_CYCLES is the worst-case length of one insert; the watchdog allows many times that.
    localparam int ITEM_CYCLES    = 2 * SET_CAPACITY + 4;
    localparam int WATCHDOG_LIMIT = 10 * ITEM_CYCLES;
    localparam int DRAIN_CYCLES   = ITEM_CYCLES + 100;
    localparam int MAX_REPORTS    = 10;

    // Ways of filling the store at the head of a random phase
    localparam int FILL_NONE   = 0;
    localparam int FILL_RANDOM = 1;
    localparam int FILL_TOP    = 2;   // 4095 down to 3840: largest possible sum

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  smallest;
        logic [VALUE_W-1:0]  largest;
        logic [SUM_W-1:0]    total;
    } set_result_t;

    // Predictor of the sorted set plus the queue of results still owed by the block.
    class set_scoreboard;
        logic [VALUE_W-1:0] members[$];   // kept ascending
        logic [SUM_W-1:0]   member_sum;
        set_result_t        expected_results[$];
        int                 failures;

        function new();
            member_sum = '0;
            failures   = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // Accepted input transfer: update the set and queue the result it causes.
        function void note_input(bit restart, logic [VALUE_W-1:0] value);
            set_result_t exp_r;
            int          pos;
            if (restart) begin
                members.delete();
                member_sum = '0;
            end
            pos = 0;
            if (value == '0) begin
                exp_r.status = ST_RANGE;
            end else begin
                while (pos < members.size() && members[pos] < value)
                    pos++;
                // duplicate test comes before the full test
                if (pos < members.size() && members[pos] == value) begin
                    exp_r.status = ST_DUPLICATE;
                end else if (members.size() >= SET_CAPACITY) begin
                    exp_r.status = ST_FULL;
                end else begin
                    members.insert(pos, value);
                    member_sum   = member_sum + SUM_W'(value);   // wraps at SUM_W
                    exp_r.status = ST_INSERTED;
                end
            end
            exp_r.count    = COUNT_W'(members.size());
            exp_r.smallest = (members.size() > 0) ? members[0] : '0;
            exp_r.largest  = (members.size() > 0) ? members[members.size() - 1] : '0;
            exp_r.total    = member_sum;
            expected_results.push_back(exp_r);
        endfunction

        // Accepted result transfer: compare with the oldest expectation.
        function void check_result(status_t status, logic [M_DATA_W-1:0] data);
            set_result_t got;
            set_result_t want;
            got.status   = status;
            got.count    = data[8:0];
            got.smallest = data[20:9];
            got.largest  = data[32:21];
            got.total    = data[52:33];
            if (expected_results.size() == 0) begin
                flag($sformatf("unexpected result: status %0d count %0d min %0d max %0d sum %0d",
                    got.status, got.count, got.smallest, got.largest, got.total));
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    flag($sformatf({"result mismatch: expected status %0d count %0d min %0d ",
                        "max %0d sum %0d, got status %0d count %0d min %0d max %0d sum %0d"},
                        want.status, want.count, want.smallest, want.largest, want.total,
                        got.status, got.count, got.smallest, got.largest, got.total));
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [11:0] value, [15:12] zero
    logic [0:0]          s_tuser  = '0;   // [0] restart
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [8:0] count, [20:9] smallest, [32:21] largest,
                                          // [52:33] total, [55:53] zero
    logic [STATUS_W-1:0] m_tuser;         // [1:0] status

    set_scoreboard      sb;
    int                 src_idle_pct  = 20;   // chance per cycle that the sender holds off
    int                 sink_idle_pct = 66;   // chance per cycle that the receiver stalls
    int                 quiet_cycles  = 0;
    logic [VALUE_W-1:0] run_values[$];        // values sent since the last restart

    sorted_set_insert #(
        .CAPACITY(SET_CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure, one draw per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Monitor and watchdog. Signals read here hold their pre-edge values, so every
    // transfer is seen exactly as the block sees it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(status_t'(m_tuser), m_tdata);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser[0], s_tdata[VALUE_W-1:0]);
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one item, with random hold-off first; returns at the edge that takes it.
    // s_tvalid gets a single assignment per step, so back-to-back transfers stay clean.
    task automatic send_value(input bit restart, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - VALUE_W){1'b0}}, value};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Value for a well-formed run: mostly fresh members, some repeats, some zeros,
    // and a narrow low window that makes neighbors and collisions common.
    function automatic logic [VALUE_W-1:0] pick_run_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 24 && run_values.size() > 0)
            return run_values[$urandom_range(run_values.size() - 1)];
        if (roll < 40)
            return VALUE_W'($urandom_range(1, 48));
        return VALUE_W'($urandom_range(1, VALUE_MAX));
    endfunction

    task automatic random_phase(input int n_items, input int fill_kind);
        int                 sent;
        int                 run_len;
        bit                 restart;
        logic [VALUE_W-1:0] v;
        bit                 in_set[int];
        sent = 0;
        if (fill_kind != FILL_NONE) begin
            // Fill the store to capacity, then keep pushing: full, duplicate and zero.
            run_values.delete();
            v       = VALUE_W'(VALUE_MAX);
            restart = 1'b1;
            while (in_set.num() < SET_CAPACITY) begin
                if (fill_kind == FILL_RANDOM)
                    v = VALUE_W'($urandom_range(1, VALUE_MAX));
                send_value(restart, v);
                restart   = 1'b0;
                in_set[v] = 1'b1;
                run_values.push_back(v);
                v = v - 1'b1;   // descending insertions under FILL_TOP: worst-case shifting
                sent++;
            end
            repeat (24) begin
                case ($urandom_range(2))
                    0: begin
                        do v = VALUE_W'($urandom_range(1, VALUE_MAX)); while (in_set.exists(v));
                    end
                    1: v = run_values[$urandom_range(run_values.size() - 1)];
                    default: v = '0;
                endcase
                send_value(1'b0, v);
                sent++;
            end
        end
        while (sent < n_items) begin
            run_len = $urandom_range(1, 32);
            if ($urandom_range(99) < 15) begin
                // noise: scattered restarts, any value
                repeat (run_len) begin
                    restart = ($urandom_range(7) == 0);
                    if (restart)
                        run_values.delete();
                    v = VALUE_W'($urandom_range(0, VALUE_MAX));
                    send_value(restart, v);
                    run_values.push_back(v);
                    sent++;
                end
            end else begin
                // a set built from scratch, now and then grown on top of the last one
                restart = ($urandom_range(9) != 0);
                if (restart)
                    run_values.delete();
                repeat (run_len) begin
                    v = pick_run_value();
                    send_value(restart, v);
                    run_values.push_back(v);
                    restart = 1'b0;
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: edges of the value range, duplicates, restarts, the empty set
        send_value(1'b0, 12'd0);      // zero on the empty set
        send_value(1'b0, 12'd4095);   // largest value
        send_value(1'b0, 12'd1);      // smallest value, goes in front
        send_value(1'b0, 12'd4095);   // duplicate of the greatest member
        send_value(1'b0, 12'd2048);
        send_value(1'b0, 12'd1);      // duplicate of the least member
        send_value(1'b0, 12'd0);      // zero with members present
        send_value(1'b0, 12'd2047);
        send_value(1'b0, 12'd2049);
        send_value(1'b1, 12'd0);      // restart with a rejected value: empty result
        send_value(1'b1, 12'd0);
        send_value(1'b1, 12'd4095);
        send_value(1'b0, 12'd4094);
        send_value(1'b1, 12'd4095);   // restart, value present before: inserted again
        send_value(1'b0, 12'd2730);
        send_value(1'b0, 12'd1365);
        send_value(1'b1, 12'd1);
        send_value(1'b0, 12'd1);
        send_value(1'b0, 12'd0);

        // Sender holds off with chance 20 in 100, receiver stalls with chance 66 in 100
        random_phase(460, FILL_RANDOM);
        // The other way round
        src_idle_pct  = 66;
        sink_idle_pct = 20;
        random_phase(460, FILL_NONE);
        // Full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(460, FILL_TOP);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        // Any extra result turns up here as unexpected
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/sset_pkg.sv
sv/sset_ctrl.sv
sv/sset_dp.sv
sv/sorted_set_insert.sv
test/sorted_set_insert_tb.sv
